### design/fenbb_pkg.sv
// Package: payload types, character codes and helpers for the FEN bitboard parser.
`default_nettype none
package fenbb_pkg;

	localparam logic [7:0] CURSOR_START = 8'd56;
	localparam logic [7:0] RANK_DROP    = 8'd16;
	localparam logic [6:0] NO_SQUARE    = 7'd64;
	localparam logic [9:0] HALF_MAX     = 10'd1023;
	localparam logic [15:0] FULL_MAX    = 16'hFFFF;
	localparam logic [2:0] FIELD_LAST   = 3'd7;
	localparam logic [1:0] LEN_MAX      = 2'd3;

	localparam logic [2:0] FIELD_BOARD  = 3'd0;
	localparam logic [2:0] FIELD_SIDE   = 3'd1;
	localparam logic [2:0] FIELD_CASTLE = 3'd2;
	localparam logic [2:0] FIELD_EP     = 3'd3;
	localparam logic [2:0] FIELD_HALF   = 3'd4;
	localparam logic [2:0] FIELD_FULL   = 3'd5;

	localparam logic [2:0] BOARD_WHITE  = 3'd0;
	localparam logic [2:0] BOARD_BLACK  = 3'd1;
	localparam logic [2:0] BOARD_PAWN   = 3'd2;
	localparam logic [2:0] BOARD_ROOK   = 3'd3;
	localparam logic [2:0] BOARD_KNIGHT = 3'd4;
	localparam logic [2:0] BOARD_BISHOP = 3'd5;
	localparam logic [2:0] BOARD_QUEEN  = 3'd6;
	localparam logic [2:0] BOARD_KING   = 3'd7;

	localparam logic [3:0] CASTLE_WK    = 4'h8;
	localparam logic [3:0] CASTLE_WQ    = 4'h4;
	localparam logic [3:0] CASTLE_BK    = 4'h2;
	localparam logic [3:0] CASTLE_BQ    = 4'h1;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_0         = 8'h30;
	localparam logic [7:0] CH_1         = 8'h31;
	localparam logic [7:0] CH_8         = 8'h38;
	localparam logic [7:0] CH_9         = 8'h39;
	localparam logic [7:0] CH_UA        = 8'h41;
	localparam logic [7:0] CH_UZ        = 8'h5A;
	localparam logic [7:0] CH_LA        = 8'h61;
	localparam logic [7:0] CH_LH        = 8'h68;
	localparam logic [7:0] CH_LZ        = 8'h7A;
	localparam logic [7:0] CH_UK        = 8'h4B;
	localparam logic [7:0] CH_UQ        = 8'h51;
	localparam logic [7:0] CH_LK        = 8'h6B;
	localparam logic [7:0] CH_LQ        = 8'h71;
	localparam logic [7:0] CH_LP        = 8'h70;
	localparam logic [7:0] CH_LR        = 8'h72;
	localparam logic [7:0] CH_LN        = 8'h6E;
	localparam logic [7:0] CH_LB        = 8'h62;
	localparam logic [7:0] CH_LW        = 8'h77;
	localparam logic [7:0] CASE_BIT     = 8'h20;

	typedef struct packed {
		logic [7:0] text_char;
		logic       end_of_string;
	} fenbb_in_t;

	typedef struct packed {
		logic [2:0]  board_id;
		logic [63:0] board_bits;
		logic        white_to_move;
		logic [3:0]  castle_rights;
		logic [6:0]  en_passant_square;
		logic [9:0]  halfmove_clock;
		logic [15:0] fullmove_number;
		logic        last_of_run;
	} fenbb_out_t;

	typedef struct packed {
		logic [7:0][63:0] boards;
		logic             side;
		logic [3:0]       castle;
		logic [6:0]       ep;
		logic [9:0]       half;
		logic [15:0]      full;
	} fenbb_snap_t;

	typedef struct packed {
		logic hit;
		logic [2:0] id;
	} fenbb_piece_t;

	function automatic fenbb_piece_t piece_of(input logic [7:0] low);
		fenbb_piece_t p;
		p.hit = 1'b1;
		case (low)
			CH_LP:   p.id = BOARD_PAWN;
			CH_LR:   p.id = BOARD_ROOK;
			CH_LN:   p.id = BOARD_KNIGHT;
			CH_LB:   p.id = BOARD_BISHOP;
			CH_LQ:   p.id = BOARD_QUEEN;
			CH_LK:   p.id = BOARD_KING;
			default: begin
				p.hit = 1'b0;
				p.id  = BOARD_WHITE;
			end
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

### design/fenbb_chan_if.sv
// Interface: valid/ready channel carrying one payload per request.
`default_nettype none
interface fenbb_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/fenbb_parser.sv
// Parser: input register and per-character update of the FEN position state.
`default_nettype none
module fenbb_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fenbb_chan_if.sink                 chars,
	output fenbb_pkg::fenbb_snap_t     snap,
	output logic                       snap_valid,
	input  wire logic                  snap_ready
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;
	logic       consume;

	logic [7:0][63:0] boards_q, boards_d;
	logic [7:0]  cursor_q, cursor_d;
	logic [2:0]  field_q, field_d;
	logic [1:0]  len_q, len_d;
	logic [7:0]  first_q, first_d;
	logic        side_q, side_d;
	logic [3:0]  castle_q, castle_d;
	logic [6:0]  ep_q, ep_d;
	logic [9:0]  half_q, half_d;
	logic [15:0] full_q, full_d;

	logic        is_upper, is_lower, is_digit;
	logic [7:0]  low_char;
	logic [3:0]  digit;
	logic [63:0] sq_bit;
	logic [13:0] half_acc;
	logic [19:0] full_acc;
	fenbb_pkg::fenbb_piece_t piece;

	assign consume     = valid_s1 && (!eos_s1 || snap_ready);
	assign chars.ready = !valid_s1 || consume;
	assign snap_valid  = valid_s1 && eos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.payload.text_char;
			eos_s1  <= chars.payload.end_of_string;
		end
	end

	assign is_upper = (char_s1 >= fenbb_pkg::CH_UA) && (char_s1 <= fenbb_pkg::CH_UZ);
	assign is_lower = (char_s1 >= fenbb_pkg::CH_LA) && (char_s1 <= fenbb_pkg::CH_LZ);
	assign is_digit = (char_s1 >= fenbb_pkg::CH_0) && (char_s1 <= fenbb_pkg::CH_9);
	assign low_char = char_s1 | fenbb_pkg::CASE_BIT;
	assign digit    = 4'(char_s1 - fenbb_pkg::CH_0);
	assign sq_bit   = 64'd1 << cursor_q[5:0];
	assign piece    = fenbb_pkg::piece_of(low_char);
	assign half_acc = ({4'd0, half_q} << 3) + ({4'd0, half_q} << 1) + {10'd0, digit};
	assign full_acc = ({4'd0, full_q} << 3) + ({4'd0, full_q} << 1) + {16'd0, digit};

	always_comb begin
		boards_d = boards_q;
		cursor_d = cursor_q;
		field_d  = field_q;
		len_d    = len_q;
		first_d  = first_q;
		side_d   = side_q;
		castle_d = castle_q;
		ep_d     = ep_q;
		half_d   = half_q;
		full_d   = full_q;
		if (char_s1 == fenbb_pkg::CH_SPACE) begin
			if (field_q != fenbb_pkg::FIELD_LAST) begin
				field_d = field_q + 3'd1;
			end
			len_d   = 2'd0;
			first_d = 8'd0;
		end else begin
			case (field_q)
				fenbb_pkg::FIELD_BOARD: begin
					if (is_upper || is_lower) begin
						if (cursor_q[7:6] == 2'd0) begin
							if (is_upper) begin
								boards_d[fenbb_pkg::BOARD_WHITE] =
									boards_q[fenbb_pkg::BOARD_WHITE] | sq_bit;
							end else begin
								boards_d[fenbb_pkg::BOARD_BLACK] =
									boards_q[fenbb_pkg::BOARD_BLACK] | sq_bit;
							end
							if (piece.hit) begin
								boards_d[piece.id] = boards_q[piece.id] | sq_bit;
							end
						end
						cursor_d = cursor_q + 8'd1;
					end else if (is_digit) begin
						cursor_d = cursor_q + {4'd0, digit};
					end else if (char_s1 == fenbb_pkg::CH_SLASH) begin
						cursor_d = cursor_q - fenbb_pkg::RANK_DROP;
					end
				end
				fenbb_pkg::FIELD_SIDE: begin
					side_d = (len_q == 2'd0) && (char_s1 == fenbb_pkg::CH_LW);
				end
				fenbb_pkg::FIELD_CASTLE: begin
					case (char_s1)
						fenbb_pkg::CH_UK: castle_d = castle_q | fenbb_pkg::CASTLE_WK;
						fenbb_pkg::CH_UQ: castle_d = castle_q | fenbb_pkg::CASTLE_WQ;
						fenbb_pkg::CH_LK: castle_d = castle_q | fenbb_pkg::CASTLE_BK;
						fenbb_pkg::CH_LQ: castle_d = castle_q | fenbb_pkg::CASTLE_BQ;
						default:          castle_d = castle_q;
					endcase
				end
				fenbb_pkg::FIELD_EP: begin
					ep_d = fenbb_pkg::NO_SQUARE;
					if (len_q == 2'd0) begin
						first_d = char_s1;
					end else if (len_q == 2'd1 &&
						first_q >= fenbb_pkg::CH_LA && first_q <= fenbb_pkg::CH_LH &&
						char_s1 >= fenbb_pkg::CH_1 && char_s1 <= fenbb_pkg::CH_8) begin
						ep_d = {1'b0, 3'(char_s1 - fenbb_pkg::CH_1),
							3'(first_q - fenbb_pkg::CH_LA)};
					end
				end
				fenbb_pkg::FIELD_HALF: begin
					if (is_digit) begin
						half_d = (half_acc > {4'd0, fenbb_pkg::HALF_MAX}) ?
							fenbb_pkg::HALF_MAX : half_acc[9:0];
					end
				end
				fenbb_pkg::FIELD_FULL: begin
					if (is_digit) begin
						full_d = (full_acc > {4'd0, fenbb_pkg::FULL_MAX}) ?
							fenbb_pkg::FULL_MAX : full_acc[15:0];
					end
				end
				default: begin
				end
			endcase
			if (len_q != fenbb_pkg::LEN_MAX) begin
				len_d = len_q + 2'd1;
			end
		end
	end

	assign snap.boards = boards_d;
	assign snap.side   = side_d;
	assign snap.castle = castle_d;
	assign snap.ep     = ep_d;
	assign snap.half   = half_d;
	assign snap.full   = full_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boards_q <= '0;
			cursor_q <= fenbb_pkg::CURSOR_START;
			field_q  <= 3'd0;
			len_q    <= 2'd0;
			first_q  <= 8'd0;
			side_q   <= 1'b0;
			castle_q <= 4'd0;
			ep_q     <= fenbb_pkg::NO_SQUARE;
			half_q   <= 10'd0;
			full_q   <= 16'd0;
		end else if (consume) begin
			if (eos_s1) begin
				boards_q <= '0;
				cursor_q <= fenbb_pkg::CURSOR_START;
				field_q  <= 3'd0;
				len_q    <= 2'd0;
				first_q  <= 8'd0;
				side_q   <= 1'b0;
				castle_q <= 4'd0;
				ep_q     <= fenbb_pkg::NO_SQUARE;
				half_q   <= 10'd0;
				full_q   <= 16'd0;
			end else begin
				boards_q <= boards_d;
				cursor_q <= cursor_d;
				field_q  <= field_d;
				len_q    <= len_d;
				first_q  <= first_d;
				side_q   <= side_d;
				castle_q <= castle_d;
				ep_q     <= ep_d;
				half_q   <= half_d;
				full_q   <= full_d;
			end
		end
	end

endmodule
`default_nettype wire

### design/fenbb_emitter.sv
// Emitter: holds a finished position and sends its eight bitboard results.
`default_nettype none
module fenbb_emitter (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fenbb_pkg::fenbb_snap_t snap,
	input  wire logic                  snap_valid,
	output logic                       snap_ready,
	fenbb_chan_if.source               results
);

	fenbb_pkg::fenbb_snap_t buf_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       last;

	assign last       = (idx_q == fenbb_pkg::BOARD_KING);
	assign snap_ready = !busy_q || (last && results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (snap_valid && snap_ready) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (busy_q && results.ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			buf_q <= snap;
		end
	end

	assign results.valid                     = busy_q;
	assign results.payload.board_id          = idx_q;
	assign results.payload.board_bits        = buf_q.boards[idx_q];
	assign results.payload.white_to_move     = buf_q.side;
	assign results.payload.castle_rights     = buf_q.castle;
	assign results.payload.en_passant_square = buf_q.ep;
	assign results.payload.halfmove_clock    = buf_q.half;
	assign results.payload.fullmove_number   = buf_q.full;
	assign results.payload.last_of_run       = last;

endmodule
`default_nettype wire

### design/fen_to_bitboard_parser.sv
// Top level: FEN string parser producing eight bitboard results per position.
// A character is registered on acceptance and then applied to the position;
// results come from the emitter buffer, loaded as a final character is consumed.
// Throughput: one character per cycle; a final character waits in the input
// register until the eighth result of the previous position has been taken.
// Reset: arst_n clears all position state (cursor at 56, no en passant square).
`default_nettype none
module fen_to_bitboard_parser (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fenbb_chan_if.sink   chars,
	fenbb_chan_if.source results
);

	fenbb_pkg::fenbb_snap_t snap;
	logic snap_valid;
	logic snap_ready;

	fenbb_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready)
	);

	fenbb_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.results    (results)
	);

	a_burst_starts: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && snap_ready |=> results.valid &&
			results.payload.board_id == fenbb_pkg::BOARD_WHITE)
		else $error("result burst did not start at board zero");

	a_burst_steps: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && !results.payload.last_of_run
		|=> results.valid &&
			results.payload.board_id == 3'($past(results.payload.board_id) + 3'd1))
		else $error("result burst skipped or repeated a board");

	a_last_is_king: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.payload.last_of_run |->
			results.payload.board_id == fenbb_pkg::BOARD_KING)
		else $error("last flag on wrong board");

	a_no_load_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |-> !snap_ready)
		else $error("new position taken while a result was stalled");

endmodule
`default_nettype wire

### test/fen_to_bitboard_parser_tb.sv
// Testbench: FEN parser fed a directed table, random FENs and noise, predictor-checked.
module fen_to_bitboard_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fenbb_pkg::*;

	typedef struct packed {
		logic [7:0]  lead;
		logic        typed;
		logic        side;
		logic [3:0]  castle;
		logic [6:0]  ep;
		logic [9:0]  half;
		logic [15:0] full;
	} row_meta_t;

	localparam int ROWS = 3;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_CHARS = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fenbb_chan_if #(.payload_t(fenbb_in_t))  chars_if ();
	fenbb_chan_if #(.payload_t(fenbb_out_t)) res_if ();

	fen_to_bitboard_parser u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted position
	logic [7:0][63:0] pos_boards;
	logic [7:0]       pos_cursor;
	logic [2:0]       pos_field;
	logic [1:0]       pos_len;
	logic [7:0]       pos_first;
	logic             pos_side;
	logic [3:0]       pos_castle;
	logic [6:0]       pos_ep;
	logic [9:0]       pos_half;
	logic [15:0]      pos_full;

	fenbb_out_t boards_due[$];
	logic [7:0] line_chars[$];

	logic      row_typed = 1'b0;
	row_meta_t row_meta;

	int send_idle_pct = 0;
	int take_stall_pct = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;

	int mismatches = 0;
	int chars_accepted = 0;
	int results_checked = 0;
	int lines_sent = 0;

	function automatic int board_for_letter(input logic [7:0] low);
		case (low)
			CH_LP:   return BOARD_PAWN;
			CH_LR:   return BOARD_ROOK;
			CH_LN:   return BOARD_KNIGHT;
			CH_LB:   return BOARD_BISHOP;
			CH_LQ:   return BOARD_QUEEN;
			CH_LK:   return BOARD_KING;
			default: return -1;
		endcase
	endfunction

	function automatic int decimal_push(input int value, input logic [7:0] c, input int max);
		int next;
		if (c < CH_0 || c > CH_9)
			return value;
		next = value * 10 + int'(c - CH_0);
		return (next > max) ? max : next;
	endfunction

	task automatic clear_position();
		pos_boards = '0;
		pos_cursor = CURSOR_START;
		pos_field  = FIELD_BOARD;
		pos_len    = '0;
		pos_first  = '0;
		pos_side   = 1'b0;
		pos_castle = '0;
		pos_ep     = NO_SQUARE;
		pos_half   = '0;
		pos_full   = '0;
	endtask

	task automatic apply_fen_char(input logic [7:0] c);
		logic       is_up;
		logic       is_low;
		logic [7:0] sq;
		int         kind;
		is_up  = (c >= CH_UA && c <= CH_UZ);
		is_low = (c >= CH_LA && c <= CH_LZ);
		if (c == CH_SPACE) begin
			if (pos_field < FIELD_LAST)
				pos_field = pos_field + 3'd1;
			pos_len   = '0;
			pos_first = '0;
		end else begin
			case (pos_field)
				FIELD_BOARD: begin
					if (is_up || is_low) begin
						if (pos_cursor < 8'd64) begin
							kind = board_for_letter(c | CASE_BIT);
							pos_boards[is_up ? BOARD_WHITE : BOARD_BLACK][pos_cursor[5:0]] = 1'b1;
							if (kind >= 0)
								pos_boards[kind][pos_cursor[5:0]] = 1'b1;
						end
						pos_cursor = pos_cursor + 8'd1;
					end else if (c >= CH_0 && c <= CH_9) begin
						pos_cursor = pos_cursor + (c - CH_0);
					end else if (c == CH_SLASH) begin
						pos_cursor = pos_cursor - RANK_DROP;
					end
				end
				FIELD_SIDE: pos_side = (pos_len == 2'd0 && c == CH_LW);
				FIELD_CASTLE: begin
					if (c == CH_UK)
						pos_castle = pos_castle | CASTLE_WK;
					else if (c == CH_UQ)
						pos_castle = pos_castle | CASTLE_WQ;
					else if (c == CH_LK)
						pos_castle = pos_castle | CASTLE_BK;
					else if (c == CH_LQ)
						pos_castle = pos_castle | CASTLE_BQ;
				end
				FIELD_EP: begin
					if (pos_len == 2'd0) begin
						pos_first = c;
						pos_ep    = NO_SQUARE;
					end else if (pos_len == 2'd1 && pos_first >= CH_LA && pos_first <= CH_LH &&
							c >= CH_1 && c <= CH_8) begin
						sq     = (c - CH_1) * 8'd8 + (pos_first - CH_LA);
						pos_ep = sq[6:0];
					end else begin
						pos_ep = NO_SQUARE;
					end
				end
				FIELD_HALF: pos_half = 10'(decimal_push(int'(pos_half), c, int'(HALF_MAX)));
				FIELD_FULL: pos_full = 16'(decimal_push(int'(pos_full), c, int'(FULL_MAX)));
				default: ;
			endcase
			if (pos_len < LEN_MAX)
				pos_len = pos_len + 2'd1;
		end
	endtask

	task automatic take_fen_char(input fenbb_in_t req);
		fenbb_out_t r;
		apply_fen_char(req.text_char);
		if (req.end_of_string) begin
			for (int k = 0; k < 8; k++) begin
				r.board_id          = 3'(k);
				r.board_bits        = pos_boards[k];
				r.white_to_move     = pos_side;
				r.castle_rights     = pos_castle;
				r.en_passant_square = pos_ep;
				r.halfmove_clock    = pos_half;
				r.fullmove_number   = pos_full;
				r.last_of_run       = (k == 7);
				if (row_typed) begin
					r.board_bits        = '0;
					r.white_to_move     = row_meta.side;
					r.castle_rights     = row_meta.castle;
					r.en_passant_square = row_meta.ep;
					r.halfmove_clock    = row_meta.half;
					r.fullmove_number   = row_meta.full;
				end
				boards_due = {boards_due, r};
			end
			clear_position();
		end
	endtask

	task automatic log_mismatch(input string what);
		if (mismatches < 40)
			$display("ERROR %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int id, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("board %0d %s: got %0h expected %0h", id, name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && chars_if.valid && chars_if.ready) begin
			chars_accepted++;
			take_fen_char(chars_if.payload);
		end
	end

	always @(posedge clk) begin : result_check
		fenbb_out_t got;
		fenbb_out_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.payload;
			results_checked++;
			if (boards_due.size() == 0) begin
				log_mismatch($sformatf("board %0d result with no position pending", got.board_id));
			end else begin
				want = boards_due.pop_front();
				check_field("board_id", want.board_id, got.board_id, want.board_id);
				check_field("board_bits", want.board_id, got.board_bits, want.board_bits);
				check_field("white_to_move", want.board_id, got.white_to_move, want.white_to_move);
				check_field("castle_rights", want.board_id, got.castle_rights, want.castle_rights);
				check_field("en_passant_square", want.board_id, got.en_passant_square,
					want.en_passant_square);
				check_field("halfmove_clock", want.board_id, got.halfmove_clock, want.halfmove_clock);
				check_field("fullmove_number", want.board_id, got.fullmove_number,
					want.fullmove_number);
				check_field("last_of_run", want.board_id, got.last_of_run, want.last_of_run);
			end
		end
	end

	// output side: random stalls, plus a long hold when asked
	initial begin : result_taker
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= take_stall_pct);
			end
		end
	end

	task automatic offer_char(input logic [7:0] c, input logic last);
		fenbb_in_t req;
		req.text_char     = c;
		req.end_of_string = last;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid   <= 1'b1;
		chars_if.payload <= req;
		do
			@(posedge clk);
		while (!chars_if.ready);
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_chars.size(); i++)
			offer_char(line_chars[i], i == line_chars.size() - 1);
		lines_sent++;
	endtask

	task automatic append_char(input logic [7:0] c);
		line_chars = {line_chars, c};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endtask

	task automatic build_noise(input int len);
		line_chars.delete();
		repeat (len)
			append_char(8'($urandom_range(255)));
	endtask

	task automatic build_fen();
		string pieces;
		int    file;
		int    gap;
		int    marks;
		int    ranks;
		pieces = "PNBRQKpnbrqk";
		ranks = $urandom_range(3, 1);
		line_chars.delete();
		for (int rank = 0; rank < ranks; rank++) begin
			if (rank != 0)
				append_char(CH_SLASH);
			file = 0;
			while (file < 8) begin
				if ($urandom_range(99) < 35) begin
					gap = $urandom_range(8 - file, 1);
					append_char(CH_0 + 8'(gap));
					file += gap;
				end else begin
					append_char(pieces[$urandom_range(11)]);
					file++;
				end
			end
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(3))
					0: append_char(CH_0);
					1: append_char(CH_9);
					2: append_char(8'($urandom_range(CH_UA, CH_UZ)));
					default: append_char(8'($urandom_range(255)));
				endcase
			end
		end
		append_char(CH_SPACE);
		gap = $urandom_range(99);
		if (gap < 70) begin
			append_char($urandom_range(1) ? CH_LW : CH_LB);
		end else if (gap < 85) begin
			if ($urandom_range(1))
				add_text("ww");
			else
				add_text("W");
		end else if (gap < 92) begin
			append_char(8'($urandom_range(8'h21, 8'h7E)));
		end
		append_char(CH_SPACE);
		marks = 0;
		if ($urandom_range(99) >= 25) begin
			if ($urandom_range(99) < 60) begin append_char(CH_UK); marks++; end
			if ($urandom_range(99) < 60) begin append_char(CH_UQ); marks++; end
			if ($urandom_range(99) < 60) begin append_char(CH_LK); marks++; end
			if ($urandom_range(99) < 60) begin append_char(CH_LQ); marks++; end
		end
		if (marks == 0)
			add_text("-");
		if ($urandom_range(99) < 10)
			append_char(8'($urandom_range(8'h21, 8'h7E)));
		append_char(CH_SPACE);
		gap = $urandom_range(99);
		if (gap < 50) begin
			add_text("-");
		end else if (gap < 85) begin
			append_char(8'($urandom_range(CH_LA, CH_LH)));
			append_char(8'($urandom_range(CH_1, CH_8)));
		end else begin
			repeat ($urandom_range(3, 1))
				append_char(8'($urandom_range(8'h21, 8'h7E)));
		end
		append_char(CH_SPACE);
		add_text($sformatf("%0d", ($urandom_range(99) < 85) ? $urandom_range(120) :
			$urandom_range(99999)));
		append_char(CH_SPACE);
		add_text($sformatf("%0d", ($urandom_range(99) < 85) ? $urandom_range(400, 1) :
			$urandom_range(9999999)));
		if ($urandom_range(99) < 10)
			add_text(" 3  x 7 9");
		if ($urandom_range(99) < 15)
			line_chars = line_chars[0:$urandom_range(line_chars.size() - 1)];
	endtask

	initial begin : stimulus
		string     row_text [ROWS];
		row_meta_t rows [ROWS];
		int        idle_mix [4];
		int        stall_mix [4];
		int        start_chars;
		row_text = '{"", "kQ9z/0 w Kqx e3", "   9999 99999"};
		rows[0] = '{lead: 8'h00, typed: 1'b1, side: 1'b0, castle: 4'h0, ep: NO_SQUARE,
			half: 10'd0, full: 16'd0};
		rows[1] = '{lead: 8'hFF, typed: 1'b0, side: 1'b0, castle: 4'h0, ep: NO_SQUARE,
			half: 10'd0, full: 16'd0};
		rows[2] = '{lead: CH_SPACE, typed: 1'b1, side: 1'b0, castle: 4'h0, ep: NO_SQUARE,
			half: HALF_MAX, full: FULL_MAX};
		idle_mix  = '{0, 57, 0, 30};
		stall_mix = '{0, 0, 57, 30};
		chars_if.valid   = 1'b0;
		chars_if.payload = '0;
		clear_position();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < ROWS; r++) begin
			line_chars.delete();
			append_char(rows[r].lead);
			add_text(row_text[r]);
			row_meta  = rows[r];
			row_typed = rows[r].typed;
			send_line();
			row_typed = 1'b0;
		end

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_mix[ph];
			take_stall_pct = stall_mix[ph];
			start_chars = chars_accepted;
			while (chars_accepted - start_chars < PHASE_CHARS) begin
				if ($urandom_range(99) < 75)
					build_fen();
				else
					build_noise($urandom_range(8, 1));
				send_line();
			end
		end

		// long output hold while input keeps coming
		send_idle_pct  = 0;
		take_stall_pct = 0;
		hold_req = 1'b1;
		repeat (3) begin
			build_noise(3);
			send_line();
		end
		chars_if.valid <= 1'b0;

		while (boards_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Run covered %0d characters in %0d strings, %0d bitboard results checked,",
			chars_accepted, lines_sent, results_checked);
		$display("across four request idle/stall mixes and a %0d-cycle output hold.", HOLD_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timeout: %0d results still pending", boards_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
design/fenbb_pkg.sv
design/fenbb_chan_if.sv
design/fenbb_parser.sv
design/fenbb_emitter.sv
design/fen_to_bitboard_parser.sv
test/fen_to_bitboard_parser_tb.sv
